// ===== sv/mpkd_pkg.sv =====
package mpkd_pkg;

   // item kinds
   localparam logic [1:0] KIND_DOWN = 2'd0;
   localparam logic [1:0] KIND_UP   = 2'd1;
   localparam logic [1:0] KIND_BIND = 2'd2;
   localparam logic [1:0] KIND_BLUR = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_PASS   = 2'd0;
   localparam logic [1:0] STATUS_INVOKE = 2'd1;
   localparam logic [1:0] STATUS_ACCEPT = 2'd2;
   localparam logic [1:0] STATUS_REJECT = 2'd3;

   // configuration register values after reset
   localparam logic [15:0] WINDOW_RESET  = 16'd250;
   localparam logic [6:0]  HCOUNT_RESET  = 7'd0;

   // handler indices are six bits wide
   localparam int MAX_HANDLERS = 64;

   // configuration register indices
   typedef enum logic {
      CSR_WINDOW   = 1'b0,
      CSR_HANDLERS = 1'b1
   } csr_index_type;

   // one input transaction
   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  key;
      logic [1:0]  mod_mode;
      logic [2:0]  press_count;
      logic [5:0]  handler_id;
      logic [31:0] time_ms;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic [1:0] status;
      logic [5:0] handler_out;
      logic       is_down;
      logic [5:0] key_out;
      logic       last;
   } rsp_type;

   // per-key state word held in the key memory
   typedef struct packed {
      logic        bound;
      logic        pressed;
      logic [2:0]  run;
      logic [31:0] last_time;
      logic [1:0]  mode;
      logic [2:0]  max_count;
      logic        act_valid;
      logic [5:0]  act_handler;
   } key_entry_type;

   // binding table word
   typedef struct packed {
      logic       valid;
      logic [5:0] handler;
   } tbl_entry_type;

endpackage

// ===== sv/multi_press_key_dispatcher.sv =====
// channel   direction  handshake                 payload
// req_      in         req_valid / req_stall     req_data  (mpkd_pkg::req_type)
// rsp_      out        rsp_valid / rsp_stall     rsp_data  (mpkd_pkg::rsp_type)
// csr_      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// after reset a clearing pass writes every table entry, NUM_KEYS*NUM_MODES*MAX_PRESSES
// entries (1024 by default), while req_stall stays high
// a key up or bind reads the key memory, then writes back and emits; a key down reads the key memory, then the table
// a blur walks the key memory with a read state and a write-back state per key, then a final result state
// one transaction is in work at a time; the result register frees the input side,
// and rsp_stall only holds the block when a new result meets a full result register
module multi_press_key_dispatcher #(
   parameter int NUM_KEYS    = 64,
   parameter int NUM_MODES   = 4,
   parameter int MAX_PRESSES = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mpkd_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mpkd_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  mpkd_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);

   import mpkd_pkg::*;

   localparam int KW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int TDEPTH = NUM_KEYS * NUM_MODES * MAX_PRESSES;
   localparam int TW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int KEW    = $bits(key_entry_type);
   localparam int TEW    = $bits(tbl_entry_type);

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_KEY      = 7'b0000100,
      ST_LOOK     = 7'b0001000,
      ST_BLUR_RD  = 7'b0010000,
      ST_BLUR_WR  = 7'b0100000,
      ST_BLUR_END = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [TW-1:0] cnt_ff, cnt_in;
   req_type       req_ff, req_in;
   key_entry_type wb_ff, wb_in;
   logic          look_ok_ff, look_ok_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [5:0]    pend_handler_ff, pend_handler_in;
   logic [5:0]    pend_key_ff, pend_key_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [15:0]   window_ff, window_in;
   logic [6:0]    hcount_ff, hcount_in;

   logic            key_rd_en, key_wr_en;
   logic [KW-1:0]   key_rd_addr, key_wr_addr;
   logic [KEW-1:0]  key_rd_data;
   key_entry_type   key_wr_data;
   logic            tbl_rd_en, tbl_wr_en;
   logic [TW-1:0]   tbl_rd_addr, tbl_wr_addr;
   logic [TEW-1:0]  tbl_rd_data;
   tbl_entry_type   tbl_wr_data;

   key_entry_type kd;
   tbl_entry_type td;
   logic          key_ok;
   logic          bind_bad;
   logic [31:0]   tdiff;
   logic          linked;
   logic [2:0]    run_new;
   logic          look_ok;
   logic          out_free;
   logic          blur_fire;
   logic          emit;
   rsp_type       emit_data;

   // flat table address of (key, mode, count)
   function automatic logic [TW-1:0] tbl_index(input logic [5:0] key,
                                                input logic [1:0] mode,
                                                input logic [2:0] count);
      logic [31:0] idx;
      idx = (32'(key) * 32'(NUM_MODES) + 32'(mode)) * 32'(MAX_PRESSES)
            + 32'(count) - 32'd1;
      return idx[TW-1:0];
   endfunction

   // per-key state memory
   mpkd_ram #(
      .WIDTH (KEW),
      .DEPTH (NUM_KEYS)
   ) key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   // binding table memory
   mpkd_ram #(
      .WIDTH (TEW),
      .DEPTH (TDEPTH)
   ) tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign kd = key_entry_type'(key_rd_data);
   assign td = tbl_entry_type'(tbl_rd_data);

   // operand checks and press run logic
   assign key_ok   = 32'(req_ff.key) < 32'(NUM_KEYS);
   assign bind_bad = !key_ok
                     || 32'(req_ff.mod_mode) >= 32'(NUM_MODES)
                     || req_ff.press_count == 3'd0
                     || 32'(req_ff.press_count) > 32'(MAX_PRESSES)
                     || {1'b0, req_ff.handler_id} >= hcount_ff
                     || 32'(req_ff.handler_id) >= 32'(MAX_HANDLERS);
   assign tdiff    = req_ff.time_ms - kd.last_time;
   assign linked   = kd.run != 3'd0 && kd.mode == req_ff.mod_mode
                     && tdiff <= {16'd0, window_ff} && kd.run < kd.max_count;
   assign run_new  = linked ? kd.run + 3'd1 : 3'd1;
   assign look_ok  = 32'(req_ff.mod_mode) < 32'(NUM_MODES)
                     && 32'(run_new) <= 32'(MAX_PRESSES);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign blur_fire = kd.pressed && kd.act_valid;

   // sequencer: read, modify, write back
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      req_in          = req_ff;
      wb_in           = wb_ff;
      look_ok_in      = look_ok_ff;
      pend_valid_in   = pend_valid_ff;
      pend_handler_in = pend_handler_ff;
      pend_key_in     = pend_key_ff;
      key_rd_en       = 1'b0;
      key_rd_addr     = req_data.key[KW-1:0];
      key_wr_en       = 1'b0;
      key_wr_addr     = req_ff.key[KW-1:0];
      key_wr_data     = kd;
      tbl_rd_en       = 1'b0;
      tbl_rd_addr     = tbl_index(req_ff.key, req_ff.mod_mode, run_new);
      tbl_wr_en       = 1'b0;
      tbl_wr_addr     = tbl_index(req_ff.key, req_ff.mod_mode, req_ff.press_count);
      tbl_wr_data     = '{valid: 1'b1, handler: req_ff.handler_id};
      emit            = 1'b0;
      emit_data       = '{status: STATUS_PASS, handler_out: 6'd0, is_down: 1'b0,
                          key_out: req_ff.key, last: 1'b1};

      unique case (state_ff)
         ST_CLEAR: begin
            key_wr_en   = 32'(cnt_ff) < 32'(NUM_KEYS);
            key_wr_addr = cnt_ff[KW-1:0];
            key_wr_data = '0;
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = cnt_ff;
            tbl_wr_data = '0;
            if (cnt_ff == TW'(TDEPTH - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               key_rd_en = 1'b1;
               if (req_data.kind == KIND_BLUR) begin
                  state_in      = ST_BLUR_RD;
                  cnt_in        = '0;
                  pend_valid_in = 1'b0;
               end else begin
                  state_in = ST_KEY;
               end
            end
         end
         ST_KEY: begin
            case (req_ff.kind)
               KIND_BIND: begin
                  if (out_free) begin
                     emit = 1'b1;
                     emit_data.status = bind_bad ? STATUS_REJECT : STATUS_ACCEPT;
                     if (!bind_bad) begin
                        tbl_wr_en             = 1'b1;
                        key_wr_en             = 1'b1;
                        key_wr_data.bound     = 1'b1;
                        key_wr_data.pressed   = 1'b0;
                        key_wr_data.run       = 3'd0;
                        key_wr_data.max_count = (req_ff.press_count > kd.max_count) ?
                                                req_ff.press_count : kd.max_count;
                     end
                     state_in = ST_IDLE;
                  end
               end
               KIND_DOWN: begin
                  if (!key_ok || !kd.bound || kd.pressed) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     // open or extend the run, then look up its handler
                     wb_in           = kd;
                     wb_in.pressed   = 1'b1;
                     wb_in.run       = run_new;
                     wb_in.last_time = req_ff.time_ms;
                     wb_in.mode      = req_ff.mod_mode;
                     look_ok_in      = look_ok;
                     tbl_rd_en       = 1'b1;
                     state_in        = ST_LOOK;
                  end
               end
               default: begin
                  // key up
                  if (out_free) begin
                     emit = 1'b1;
                     if (key_ok && kd.bound && kd.pressed) begin
                        key_wr_en           = 1'b1;
                        key_wr_data.pressed = 1'b0;
                        if (kd.act_valid) begin
                           emit_data.status      = STATUS_INVOKE;
                           emit_data.handler_out = kd.act_handler;
                        end
                     end
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_LOOK: begin
            if (out_free) begin
               key_wr_en             = 1'b1;
               key_wr_data           = wb_ff;
               key_wr_data.act_valid = look_ok_ff && td.valid;
               emit                  = 1'b1;
               if (look_ok_ff && td.valid) begin
                  key_wr_data.act_handler = td.handler;
                  emit_data.status        = STATUS_INVOKE;
                  emit_data.handler_out   = td.handler;
                  emit_data.is_down       = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_BLUR_RD: begin
            key_rd_en   = 1'b1;
            key_rd_addr = cnt_ff[KW-1:0];
            state_in    = ST_BLUR_WR;
         end
         ST_BLUR_WR: begin
            // a release found while one is held pushes the held one out
            if (!(blur_fire && pend_valid_ff) || out_free) begin
               key_wr_en           = 1'b1;
               key_wr_addr         = cnt_ff[KW-1:0];
               key_wr_data.pressed = 1'b0;
               key_wr_data.run     = 3'd0;
               if (blur_fire) begin
                  if (pend_valid_ff) begin
                     emit      = 1'b1;
                     emit_data = '{status: STATUS_INVOKE, handler_out: pend_handler_ff,
                                   is_down: 1'b0, key_out: pend_key_ff, last: 1'b0};
                  end
                  pend_valid_in   = 1'b1;
                  pend_handler_in = kd.act_handler;
                  pend_key_in     = 6'(cnt_ff[KW-1:0]);
               end
               if (cnt_ff[KW-1:0] == KW'(NUM_KEYS - 1)) begin
                  state_in = ST_BLUR_END;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_BLUR_RD;
               end
            end
         end
         ST_BLUR_END: begin
            if (out_free) begin
               emit = 1'b1;
               if (pend_valid_ff) begin
                  emit_data = '{status: STATUS_INVOKE, handler_out: pend_handler_ff,
                                is_down: 1'b0, key_out: pend_key_ff, last: 1'b1};
               end else begin
                  emit_data = '{status: STATUS_PASS, handler_out: 6'd0,
                                is_down: 1'b0, key_out: 6'd0, last: 1'b1};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = emit ? emit_data : rsp_ff;

   // configuration writes
   always_comb begin
      window_in = window_ff;
      hcount_in = hcount_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW:   window_in = csr_wdata;
            CSR_HANDLERS: hcount_in = csr_wdata[6:0];
            default:      window_in = window_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         window_ff     <= WINDOW_RESET;
         hcount_ff     <= HCOUNT_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         window_ff     <= window_in;
         hcount_ff     <= hcount_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      wb_ff           <= wb_in;
      look_ok_ff      <= look_ok_in;
      pend_handler_ff <= pend_handler_in;
      pend_key_ff     <= pend_key_in;
      rsp_ff          <= rsp_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit && rsp_valid_ff |-> !rsp_stall)
      else $error("result register overwritten while stalled");

   // the table is only written by the clearing pass or a bind
   a_tbl_write_src: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> (state_ff == ST_CLEAR || (state_ff == ST_KEY && req_ff.kind == KIND_BIND)))
      else $error("unexpected binding table write");

   // the final result of a transaction returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      emit && emit_data.last |=> state_ff == ST_IDLE)
      else $error("final result without return to idle");

   // a press invoke comes only from the table lookup of a key down
   a_press_from_look: assert property (@(posedge clock) disable iff (reset)
      emit && emit_data.is_down |-> state_ff == ST_LOOK && req_ff.kind == KIND_DOWN)
      else $error("press result outside key down lookup");

endmodule

// ===== sv/mpkd_ram.sv =====
module mpkd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import mpkd_pkg::*;

   localparam int KEY_COUNT      = 64;
   localparam int SLOT_COUNT     = 1024;
   localparam int PRESS_MAX      = 4;
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int DRAIN_CYCLES   = 200;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_WINDOW;
   logic [15:0]   csr_wdata = '0;

   // stimulus and scoreboard storage
   req_type     key_events_q[$];
   rsp_type     pending_results[$];
   int          events_queued = 0;
   logic [31:0] now_ms = '0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          req_fired = 1'b0;
   bit          run_failed = 1'b0;
   int          quiet_cycles = 0;

   // shadow of the dispatcher state
   logic [15:0] window_cfg = WINDOW_RESET;
   logic [6:0]  hcount_cfg = HCOUNT_RESET;
   bit          bind_ok  [SLOT_COUNT];
   bit [5:0]    bind_hid [SLOT_COUNT];
   bit          bound    [KEY_COUNT];
   bit          pressed  [KEY_COUNT];
   bit [2:0]    run_len  [KEY_COUNT];
   bit [31:0]   last_t   [KEY_COUNT];
   bit [1:0]    last_mode[KEY_COUNT];
   bit [2:0]    top_count[KEY_COUNT];
   bit          act_valid[KEY_COUNT];
   bit [5:0]    act_hid  [KEY_COUNT];

   multi_press_key_dispatcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // expected result store
   function automatic void push_result(logic [1:0] st, logic [5:0] hid, logic dn,
                                       logic [5:0] k, logic lst);
      rsp_type r;
      r.status      = st;
      r.handler_out = hid;
      r.is_down     = dn;
      r.key_out     = k;
      r.last        = lst;
      pending_results = {pending_results, r};
   endfunction

   // dispatch one accepted event through the shadow state
   function automatic void predict_event(req_type ev);
      logic [9:0]  slot;
      logic [2:0]  cnt_m1;
      logic [31:0] gap;
      logic        linked;
      logic [2:0]  run;
      int          final_key;
      final_key = -1;
      case (ev.kind)
         KIND_BLUR: begin
            for (int k = 0; k < KEY_COUNT; k++)
               if (pressed[k] && act_valid[k]) final_key = k;
            for (int k = 0; k < KEY_COUNT; k++) begin
               if (pressed[k] && act_valid[k])
                  push_result(STATUS_INVOKE, act_hid[k], 1'b0, 6'(k), k == final_key);
               pressed[k] = 1'b0;
               run_len[k] = '0;
            end
            if (final_key < 0) push_result(STATUS_PASS, '0, 1'b0, '0, 1'b1);
         end
         KIND_BIND: begin
            if (ev.press_count == 3'd0 || ev.press_count > 3'(PRESS_MAX) ||
                {1'b0, ev.handler_id} >= hcount_cfg) begin
               push_result(STATUS_REJECT, '0, 1'b0, ev.key, 1'b1);
            end else begin
               cnt_m1 = ev.press_count - 3'd1;
               slot = {ev.key, ev.mod_mode, cnt_m1[1:0]};
               bind_ok[slot]  = 1'b1;
               bind_hid[slot] = ev.handler_id;
               bound[ev.key]   = 1'b1;
               pressed[ev.key] = 1'b0;
               run_len[ev.key] = '0;
               if (ev.press_count > top_count[ev.key]) top_count[ev.key] = ev.press_count;
               push_result(STATUS_ACCEPT, '0, 1'b0, ev.key, 1'b1);
            end
         end
         default: begin
            if (!bound[ev.key]) begin
               push_result(STATUS_PASS, '0, 1'b0, ev.key, 1'b1);
            end else if (ev.kind == KIND_DOWN) begin
               if (pressed[ev.key]) begin
                  push_result(STATUS_PASS, '0, 1'b0, ev.key, 1'b1);
               end else begin
                  // extend the open run or start a new one
                  gap = ev.time_ms - last_t[ev.key];
                  linked = run_len[ev.key] != 3'd0 && last_mode[ev.key] == ev.mod_mode &&
                           gap <= {16'd0, window_cfg} && run_len[ev.key] < top_count[ev.key];
                  run = linked ? run_len[ev.key] + 3'd1 : 3'd1;
                  pressed[ev.key]   = 1'b1;
                  run_len[ev.key]   = run;
                  last_t[ev.key]    = ev.time_ms;
                  last_mode[ev.key] = ev.mod_mode;
                  cnt_m1 = run - 3'd1;
                  slot = {ev.key, ev.mod_mode, cnt_m1[1:0]};
                  if (run <= 3'(PRESS_MAX) && bind_ok[slot]) begin
                     act_valid[ev.key] = 1'b1;
                     act_hid[ev.key]   = bind_hid[slot];
                     push_result(STATUS_INVOKE, bind_hid[slot], 1'b1, ev.key, 1'b1);
                  end else begin
                     act_valid[ev.key] = 1'b0;
                     push_result(STATUS_PASS, '0, 1'b0, ev.key, 1'b1);
                  end
               end
            end else if (!pressed[ev.key]) begin
               push_result(STATUS_PASS, '0, 1'b0, ev.key, 1'b1);
            end else begin
               pressed[ev.key] = 1'b0;
               if (act_valid[ev.key])
                  push_result(STATUS_INVOKE, act_hid[ev.key], 1'b0, ev.key, 1'b1);
               else
                  push_result(STATUS_PASS, '0, 1'b0, ev.key, 1'b1);
            end
         end
      endcase
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         run_failed = 1'b1;
      end
   endfunction

   function automatic void queue_event(logic [1:0] kind, logic [5:0] k, logic [1:0] mode,
                                       logic [2:0] cnt, logic [5:0] hid, logic [31:0] t);
      req_type ev;
      ev.kind        = kind;
      ev.key         = k;
      ev.mod_mode    = mode;
      ev.press_count = cnt;
      ev.handler_id  = hid;
      ev.time_ms     = t;
      key_events_q = {key_events_q, ev};
      events_queued++;
   endfunction

   // random traffic: mostly press runs on a few keys, plus binds, blurs and noise
   task automatic add_random_events(int n);
      int         target;
      int         pick;
      int         presses;
      int         wide;
      logic [5:0] k;
      logic [1:0] m;
      logic [5:0] pool [6];
      target = events_queued + n;
      foreach (pool[i]) pool[i] = 6'($urandom_range(0, 63));
      while (events_queued < target) begin
         pick = $urandom_range(0, 99);
         k = pool[$urandom_range(0, 5)];
         m = ($urandom_range(0, 9) < 7) ? 2'd0 : 2'($urandom_range(0, 3));
         wide = int'(window_cfg) + int'(window_cfg) / 4 + 2;
         if (pick < 55) begin
            presses = $urandom_range(1, 4);
            for (int p = 0; p < presses; p++) begin
               now_ms += $urandom_range(0, wide);
               queue_event(KIND_DOWN, k,
                           ($urandom_range(0, 7) == 0) ? 2'($urandom) : m,
                           3'($urandom), 6'($urandom), now_ms);
               if ($urandom_range(0, 9) != 0) begin
                  now_ms += $urandom_range(0, wide / 2);
                  queue_event(KIND_UP, k, m, 3'($urandom), 6'($urandom), now_ms);
               end
            end
         end else if (pick < 72) begin
            queue_event(KIND_BIND, k, m,
                        ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom),
                        6'($urandom), now_ms);
         end else if (pick < 77) begin
            queue_event(KIND_BLUR, 6'($urandom), 2'($urandom), 3'($urandom), 6'($urandom),
                        now_ms);
         end else if (pick < 85) begin
            now_ms += $urandom();
            queue_event(2'($urandom_range(0, 1)), k, m, 3'($urandom), 6'($urandom), now_ms);
         end else begin
            queue_event(2'($urandom), 6'($urandom), 2'($urandom), 3'($urandom), 6'($urandom),
                        $urandom());
         end
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WINDOW) window_cfg = val;
      else hcount_cfg = val[6:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every queued transaction has gone in and every result came back
   task automatic wait_idle();
      while (key_events_q.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin : drive_req
      logic take_next;
      if (!reset) begin
         take_next = !req_valid || req_fired;
         req_fired = 1'b0;
         if (take_next) begin
            if (key_events_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data  <= key_events_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin : watch_channels
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_event(req_data);
            req_fired = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with nothing expected: %p", rsp_data);
               run_failed = 1'b1;
            end else begin
               want = pending_results.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("handler_out", want.handler_out, rsp_data.handler_out);
               check_field("is_down", want.is_down, rsp_data.is_down);
               check_field("key_out", want.key_out, rsp_data.key_out);
               check_field("last", want.last, rsp_data.last);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 22;
      recv_idle_pct = 84;
      write_csr(CSR_WINDOW, 16'd250);
      write_csr(CSR_HANDLERS, 16'd64);

      // unbound key, empty blur
      queue_event(KIND_DOWN, 6'd5, 2'd0, 3'd0, 6'd0, 32'd10);
      queue_event(KIND_UP, 6'd5, 2'd0, 3'd0, 6'd0, 32'd20);
      queue_event(KIND_BLUR, 6'd0, 2'd0, 3'd0, 6'd0, 32'd30);
      // binds at the extremes, bad press counts
      queue_event(KIND_BIND, 6'd63, 2'd3, 3'd4, 6'd63, 32'd40);
      queue_event(KIND_BIND, 6'd0, 2'd0, 3'd0, 6'd7, 32'd40);
      queue_event(KIND_BIND, 6'd0, 2'd0, 3'd5, 6'd0, 32'd40);
      queue_event(KIND_BIND, 6'd0, 2'd0, 3'd7, 6'd0, 32'd40);
      queue_event(KIND_BIND, 6'd0, 2'd0, 3'd1, 6'd0, 32'd40);
      queue_event(KIND_BIND, 6'd0, 2'd0, 3'd2, 6'd1, 32'd40);
      // single press, repeated down and up
      queue_event(KIND_DOWN, 6'd0, 2'd0, 3'd0, 6'd0, 32'd100);
      queue_event(KIND_DOWN, 6'd0, 2'd0, 3'd0, 6'd0, 32'd120);
      queue_event(KIND_UP, 6'd0, 2'd0, 3'd0, 6'd0, 32'd130);
      queue_event(KIND_UP, 6'd0, 2'd0, 3'd0, 6'd0, 32'd140);
      // double press, then a third press past the highest bound count
      queue_event(KIND_DOWN, 6'd0, 2'd0, 3'd0, 6'd0, 32'd300);
      queue_event(KIND_UP, 6'd0, 2'd0, 3'd0, 6'd0, 32'd310);
      queue_event(KIND_DOWN, 6'd0, 2'd0, 3'd0, 6'd0, 32'd350);
      queue_event(KIND_UP, 6'd0, 2'd0, 3'd0, 6'd0, 32'd360);
      // mode change breaks the run, no binding in that mode
      queue_event(KIND_DOWN, 6'd0, 2'd1, 3'd0, 6'd0, 32'd400);
      queue_event(KIND_UP, 6'd0, 2'd1, 3'd0, 6'd0, 32'd410);
      // run across the timestamp wrap
      queue_event(KIND_DOWN, 6'd0, 2'd0, 3'd0, 6'd0, 32'hFFFF_FF80);
      queue_event(KIND_UP, 6'd0, 2'd0, 3'd0, 6'd0, 32'hFFFF_FFA0);
      queue_event(KIND_DOWN, 6'd0, 2'd0, 3'd0, 6'd0, 32'h0000_0040);
      queue_event(KIND_DOWN, 6'd63, 2'd3, 3'd7, 6'd63, 32'hFFFF_FFFF);
      queue_event(KIND_BLUR, 6'd63, 2'd3, 3'd7, 6'd63, 32'hFFFF_FFFF);
      add_random_events(60);
      wait_idle();

      // widest window; every key pressed with a handler, then one blur
      write_csr(CSR_WINDOW, 16'hFFFF);
      now_ms = 32'hFFFF_F000;
      for (int k = 0; k < KEY_COUNT; k++)
         queue_event(KIND_BIND, 6'(k), 2'd0, 3'd1, 6'($urandom), now_ms);
      for (int k = 0; k < KEY_COUNT; k++)
         queue_event(KIND_DOWN, 6'(k), 2'd0, 3'($urandom), 6'($urandom), now_ms + 32'(k));
      queue_event(KIND_BLUR, 6'($urandom), 2'($urandom), 3'($urandom), 6'($urandom), now_ms);
      add_random_events(40);
      wait_idle();

      // sender idles heavily, receiver lightly
      send_idle_pct = 84;
      recv_idle_pct = 22;
      write_csr(CSR_WINDOW, 16'd0);
      write_csr(CSR_HANDLERS, 16'd0);
      add_random_events(50);
      wait_idle();

      write_csr(CSR_WINDOW, 16'($urandom_range(1, 2000)));
      write_csr(CSR_HANDLERS, 16'($urandom_range(1, 63)));
      add_random_events(70);
      wait_idle();

      // back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_WINDOW, 16'd250);
      write_csr(CSR_HANDLERS, 16'd64);
      add_random_events(60);
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!run_failed)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
